// ----- rtl/core/bpsd_pkg.sv -----
// Shared types and constants for the biphase stripe bit decoder.
// No dependencies; imported by bpsd_core and biphase_stripe_bit_decoder.
package bpsd_pkg;

    localparam int BLOCK_BYTES = 32;
    localparam int BYTE_BITS   = 8;

    localparam int SAMPLE_W = 10;
    localparam int STAMP_W  = 16;
    localparam int COUNT_W  = 8;
    localparam int TRANS_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int BITCNT_W = 4;
    localparam int IN_TDATA_W = 32;
    localparam int CFG_ADDR_W = 2;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST   = 10'd512;
    localparam logic [TRANS_W-1:0]  PREAMBLE_RST    = 7'd10;
    localparam logic [TRANS_W-1:0]  CALIBRATION_RST = 7'd30;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SLICE_THRESHOLD = 2'd0,
        CFG_PREAMBLE        = 2'd1,
        CFG_CALIBRATION     = 2'd2
    } t_cfg_addr;

    typedef struct packed {
        logic [TRANS_W-1:0] preamble_transitions;
        logic [TRANS_W-1:0] calibration_transitions;
    } t_count_cfg;

    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] data_byte;
        logic                 block_end;
    } t_result;

endpackage

// ----- rtl/core/bpsd_core.sv -----
// Transition timing, interval classification and byte assembly.
// Depends on bpsd_pkg; one sliced level and timestamp are processed per enabled cycle.
module bpsd_core import bpsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_level,
    input  logic [STAMP_W-1:0] i_stamp,
    input  t_count_cfg         i_cfg,
    output t_result            o_result
);

    logic                 r_prev_level,    n_prev_level;
    logic [COUNT_W-1:0]   r_trans_count,   n_trans_count;
    logic [STAMP_W-1:0]   r_mark_time,     n_mark_time;
    logic [STAMP_W-1:0]   r_low_half,      n_low_half;
    logic [STAMP_W-1:0]   r_high_half,     n_high_half;
    logic                 r_half_one,      n_half_one;
    logic [BITCNT_W-1:0]  r_bits_in_byte,  n_bits_in_byte;
    logic [BYTE_BITS-1:0] r_shift_byte,    n_shift_byte;
    logic [INDEX_W-1:0]   r_byte_index,    n_byte_index;

    logic [STAMP_W-1:0]   span;
    logic [STAMP_W-1:0]   ref_time;
    logic [STAMP_W-1:0]   long_limit;
    logic [STAMP_W:0]     ref_sum;
    logic [STAMP_W-1:0]   ref_avg;
    logic [COUNT_W-1:0]   preamble;
    logic [COUNT_W-1:0]   timing_end;
    logic [BITCNT_W-1:0]  bits_inc;
    logic                 is_long;
    logic                 take;
    logic                 bit_val;

    assign preamble   = {1'b0, i_cfg.preamble_transitions};
    assign timing_end = preamble + {1'b0, i_cfg.calibration_transitions};
    assign span       = i_stamp - r_mark_time;
    // A rising level ends a low interval, a falling level ends a high one.
    assign ref_time   = i_level ? r_low_half : r_high_half;
    assign long_limit = ref_time - {2'b00, ref_time[STAMP_W-1:2]};
    assign is_long    = (span >= long_limit);
    assign ref_sum    = {1'b0, span} + {1'b0, ref_time};
    assign ref_avg    = ref_sum[STAMP_W:1];
    assign bits_inc   = r_bits_in_byte + BITCNT_W'(1);

    always_comb begin
        n_prev_level   = r_prev_level;
        n_trans_count  = r_trans_count;
        n_mark_time    = r_mark_time;
        n_low_half     = r_low_half;
        n_high_half    = r_high_half;
        n_half_one     = r_half_one;
        n_bits_in_byte = r_bits_in_byte;
        n_shift_byte   = r_shift_byte;
        n_byte_index   = r_byte_index;
        take           = 1'b0;
        bit_val        = 1'b0;
        o_result       = '0;

        if (i_en && (i_level != r_prev_level)) begin
            n_prev_level = i_level;
            if (r_trans_count < preamble) begin
                n_trans_count = r_trans_count + COUNT_W'(1);
            end else if (r_trans_count == preamble) begin
                n_mark_time   = i_stamp;
                n_trans_count = r_trans_count + COUNT_W'(1);
            end else begin
                n_mark_time = i_stamp;
                if (r_trans_count < timing_end) begin
                    if (i_level) begin
                        n_low_half = span;
                    end else begin
                        n_high_half = span;
                    end
                    n_trans_count = r_trans_count + COUNT_W'(1);
                end else begin
                    if (is_long) begin
                        if (i_level) begin
                            n_low_half = ref_avg;
                        end else begin
                            n_high_half = ref_avg;
                        end
                        bit_val = 1'b0;
                        take    = 1'b1;
                    end else begin
                        // Only the first short half of a pair yields a one.
                        n_half_one = ~r_half_one;
                        bit_val    = 1'b1;
                        take       = ~r_half_one;
                    end
                end
            end
        end

        if (take) begin
            n_shift_byte   = {r_shift_byte[BYTE_BITS-2:0], bit_val};
            n_bits_in_byte = bits_inc;
            if (bits_inc == BITCNT_W'(BYTE_BITS)) begin
                o_result.valid     = 1'b1;
                o_result.data_byte = n_shift_byte;
                n_bits_in_byte     = '0;
                n_shift_byte       = '0;
                if (r_byte_index >= INDEX_W'(BLOCK_BYTES - 1)) begin
                    o_result.block_end = 1'b1;
                    n_byte_index       = '0;
                end else begin
                    n_byte_index = r_byte_index + INDEX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b0;
            r_trans_count  <= '0;
            r_mark_time    <= '0;
            r_low_half     <= '0;
            r_high_half    <= '0;
            r_half_one     <= 1'b0;
            r_bits_in_byte <= '0;
            r_shift_byte   <= '0;
            r_byte_index   <= '0;
        end else begin
            r_prev_level   <= n_prev_level;
            r_trans_count  <= n_trans_count;
            r_mark_time    <= n_mark_time;
            r_low_half     <= n_low_half;
            r_high_half    <= n_high_half;
            r_half_one     <= n_half_one;
            r_bits_in_byte <= n_bits_in_byte;
            r_shift_byte   <= n_shift_byte;
            r_byte_index   <= n_byte_index;
        end
    end

endmodule

// ----- rtl/core/biphase_stripe_bit_decoder.sv -----
// Top level of the biphase stripe bit decoder: configuration registers,
// input slicing stage and output register around bpsd_core. Depends on bpsd_pkg.
//
// The slave stream carries one head sample and a timer value per transaction.
// The sample is sliced against the threshold register in the input stage; the
// next stage detects level changes, times intervals and assembles bits. Each
// completed byte leaves on the master stream, with tlast marking the last byte
// of every block of BLOCK_BYTES bytes. Most samples produce no transaction.
// Throughput is one sample per cycle while the master side takes bytes. A sample
// accepted into the input register is decoded from it once the output register
// is free, and its byte then waits in the output register, valid on the master
// side. When the master side stalls with a byte waiting, an empty input register
// still takes one more sample, and then tready drops until the byte is taken. Reset
// (synchronous, active low) clears all decode state and loads the register defaults:
// threshold 512, preamble 10, calibration 30 transitions. Registers are to be written
// by the user through i_cfg_we/i_cfg_addr/i_cfg_wdata only while idle; not enforced.
module biphase_stripe_bit_decoder import bpsd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,   // sample[9:0], timestamp[25:10], zeros
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [BYTE_BITS-1:0]  o_m_axis_tdata,   // data_byte[7:0]
    output logic                  o_m_axis_tlast,   // block_end
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SAMPLE_W-1:0]   i_cfg_wdata
);

    logic [SAMPLE_W-1:0]  r_slice_threshold;
    t_count_cfg           r_count_cfg;

    logic                 r_s1_valid;
    logic                 r_s1_level;
    logic [STAMP_W-1:0]   r_s1_stamp;

    logic                 r_out_valid;
    logic [BYTE_BITS-1:0] r_out_data;
    logic                 r_out_last;

    logic                 out_free;
    logic                 in_accept;
    logic                 core_en;
    t_result              core_result;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign core_en         = r_s1_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_threshold                   <= THRESHOLD_RST;
            r_count_cfg.preamble_transitions    <= PREAMBLE_RST;
            r_count_cfg.calibration_transitions <= CALIBRATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SLICE_THRESHOLD: r_slice_threshold <= i_cfg_wdata;
                CFG_PREAMBLE:
                    r_count_cfg.preamble_transitions <= i_cfg_wdata[TRANS_W-1:0];
                CFG_CALIBRATION:
                    r_count_cfg.calibration_transitions <= i_cfg_wdata[TRANS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: slice the sample and hold it with its timestamp.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_level <= (i_s_axis_tdata[SAMPLE_W-1:0] > r_slice_threshold);
            r_s1_stamp <= i_s_axis_tdata[SAMPLE_W +: STAMP_W];
        end
    end

    bpsd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (core_en),
        .i_level  (r_s1_level),
        .i_stamp  (r_s1_stamp),
        .i_cfg    (r_count_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= core_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && core_result.valid) begin
            r_out_data <= core_result.data_byte;
            r_out_last <= core_result.block_end;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // The decode stage never runs while a byte is stuck in the output register.
    a_no_decode_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !core_en)
        else $error("decode stage ran while the output register was blocked");

    // An empty input stage is always ready for a new sample.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_s_axis_tready)
        else $error("input stage empty but not ready");

    // A held sample that is decoded and not replaced leaves the input stage.
    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_en && !in_accept) |=> !r_s1_valid)
        else $error("input stage kept a sample that was already decoded");

    // A result is only produced from a sample that is being decoded.
    a_result_needs_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_result.valid |-> core_en)
        else $error("decode result without an enabled sample");

endmodule
